@@ rtl/bzs_pkg.sv @@
// Shared constants, command and status types for the cubic Bezier segment stepper.
`default_nettype none
package bzs_pkg;

  localparam int FRAC_BITS_DEF = 10;
  localparam int WORD_W        = 32;
  localparam int WAIT_W        = 16;
  localparam int POS_W         = 22;
  localparam int CFG_IDX_W     = 3;
  localparam int CNT_W         = 4;
  localparam int REM_W         = 3;
  localparam int RECIP_SHIFT   = 34;

  localparam logic signed [WORD_W-1:0] DONE_LIMIT = 32'sd950;
  localparam logic [REM_W:0]           TICK_DIV   = 4'd5;
  localparam logic [WORD_W-1:0]        RECIP5     = 32'hCCCC_CCCD;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_START_POINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CONTROL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_CONTROL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_POINT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_WAIT       = 3'd5;

  typedef enum logic [2:0] {
    COEF_NONE,
    COEF_DIFF,
    COEF_TRIPLE,
    COEF_SUBLIN,
    COEF_SUBQUAD
  } coef_op_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_PARAM,
    MUL_T2,
    MUL_T3,
    MUL_LINX,
    MUL_LINY,
    MUL_QUADX,
    MUL_QUADY,
    MUL_CUBEX,
    MUL_CUBEY
  } mul_sel_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_POS,
    EMIT_OFF
  } emit_t;

  typedef struct packed {
    logic     load;
    coef_op_t coef_op;
    logic     div_step;
    logic     pos_init;
    mul_sel_t mul_sel;
    logic     wait_dec;
    emit_t    emit;
  } bzs_cmd_t;

  typedef struct packed {
    logic is_start;
    logic running;
    logic in_range;
    logic wait_nz;
    logic result_free;
  } bzs_sts_t;

endpackage
`default_nettype wire

@@ rtl/cubic_bezier_segment_stepper_unit.sv @@
// Cubic Bezier segment stepper: one item at a time through a shared 32x32 multiplier.
// A start item passes through the decide, triple, subtract-linear and subtract-quadratic states to emit;
// a curve tick takes a divide step and the multiply schedule before emit; other tick items
// go from decide straight to emit. No new item is taken until the result has left emit.
// Synchronous reset clears all registers, the segment state and the output valid.
`default_nettype none
module cubic_bezier_segment_stepper_unit #(
  parameter int FRACTION_BITS = bzs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire logic                            cmd,
  input  wire logic [bzs_pkg::WORD_W-1:0]      tick,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic                                 active,
  output logic signed [bzs_pkg::POS_W-1:0]     pos_x,
  output logic signed [bzs_pkg::POS_W-1:0]     pos_y,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bzs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bzs_pkg::WORD_W-1:0]      cfg_data
);
  import bzs_pkg::*;

  bzs_cmd_t ctl;
  bzs_sts_t sts;

  bzs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .ctl        (ctl)
  );

  bzs_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .tick         (tick),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .active       (active),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ctl          (ctl),
    .sts          (sts)
  );

endmodule
`default_nettype wire

@@ rtl/bzs_ctrl.sv @@
// Sequencing state machine for the cubic Bezier segment stepper.
`default_nettype none
module bzs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire bzs_pkg::bzs_sts_t sts,
  output bzs_pkg::bzs_cmd_t      ctl
);
  import bzs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_TRIPLE,
    ST_SUBLIN,
    ST_SUBQUAD,
    ST_DIVIDE,
    ST_MULT,
    ST_EMIT
  } state_t;

  localparam logic [CNT_W-1:0] MULT_LAST = 4'd10;

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  emit_t             emit_kind, emit_kind_next;

  // Multiplier schedule; each product is written back in the cycle after its issue.
  function automatic mul_sel_t mult_sched(input logic [CNT_W-1:0] step);
    mul_sel_t sel;
    begin
      unique case (step)
        4'd0:    sel = MUL_PARAM;
        4'd2:    sel = MUL_T2;
        4'd3:    sel = MUL_LINX;
        4'd4:    sel = MUL_T3;
        4'd5:    sel = MUL_LINY;
        4'd6:    sel = MUL_QUADX;
        4'd7:    sel = MUL_QUADY;
        4'd8:    sel = MUL_CUBEX;
        4'd9:    sel = MUL_CUBEY;
        default: sel = MUL_NONE;
      endcase
      return sel;
    end
  endfunction

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    ctl            = '0;
    state_next     = state;
    cnt_next       = cnt;
    emit_kind_next = emit_kind;
    unique case (state)
      ST_IDLE: begin
        ctl.load = item_valid;
        if (item_valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.is_start) begin
          ctl.coef_op = COEF_DIFF;
          state_next  = ST_TRIPLE;
        end else if (!sts.running) begin
          emit_kind_next = EMIT_OFF;
          state_next     = ST_EMIT;
        end else if (sts.in_range) begin
          cnt_next   = '0;
          state_next = ST_DIVIDE;
        end else if (sts.wait_nz) begin
          ctl.wait_dec   = 1'b1;
          emit_kind_next = EMIT_POS;
          state_next     = ST_EMIT;
        end else begin
          emit_kind_next = EMIT_OFF;
          state_next     = ST_EMIT;
        end
      end
      ST_TRIPLE: begin
        ctl.coef_op = COEF_TRIPLE;
        state_next  = ST_SUBLIN;
      end
      ST_SUBLIN: begin
        ctl.coef_op = COEF_SUBLIN;
        state_next  = ST_SUBQUAD;
      end
      ST_SUBQUAD: begin
        ctl.coef_op    = COEF_SUBQUAD;
        emit_kind_next = EMIT_POS;
        state_next     = ST_EMIT;
      end
      ST_DIVIDE: begin
        ctl.div_step = 1'b1;
        cnt_next     = '0;
        state_next   = ST_MULT;
      end
      ST_MULT: begin
        ctl.mul_sel  = mult_sched(cnt);
        ctl.pos_init = (cnt == '0);
        if (cnt == MULT_LAST) begin
          emit_kind_next = EMIT_POS;
          state_next     = ST_EMIT;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (sts.result_free) begin
          ctl.emit   = emit_kind;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      emit_kind <= EMIT_NONE;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      emit_kind <= emit_kind_next;
    end
  end

  a_emit_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit != EMIT_NONE) |=> (state == ST_IDLE))
    else $error("Controller did not return to idle after a result transfer.");

  a_mult_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULT) |-> (cnt <= MULT_LAST))
    else $error("Multiply schedule count ran past its last step.");

  a_load_decides: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> (state == ST_DECIDE))
    else $error("Accepted item was not followed by a decision cycle.");

endmodule
`default_nettype wire

@@ rtl/bzs_dp.sv @@
// Datapath: configuration, segment state, divide by five, shared multiplier and result register.
`default_nettype none
module bzs_dp #(
  parameter int FRACTION_BITS = bzs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cmd,
  input  wire logic [bzs_pkg::WORD_W-1:0]      tick,
  input  wire logic                            result_stall,
  output logic                                 result_valid,
  output logic                                 active,
  output logic signed [bzs_pkg::POS_W-1:0]     pos_x,
  output logic signed [bzs_pkg::POS_W-1:0]     pos_y,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bzs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bzs_pkg::WORD_W-1:0]      cfg_data,
  input  wire bzs_pkg::bzs_cmd_t               ctl,
  output bzs_pkg::bzs_sts_t                    sts
);
  import bzs_pkg::*;

  logic [WORD_W-1:0] start_point, first_control, second_control, end_point, step_size;
  logic [WAIT_W-1:0] end_wait;

  logic              item_cmd;
  logic [WORD_W-1:0] item_tick;
  logic              running;
  logic [WORD_W-1:0] begin_tick, curve_param, t2, t3;
  logic [WORD_W-1:0] lin_x, lin_y, quad_x, quad_y, cube_x, cube_y;
  logic [WORD_W-1:0] cur_pos_x, cur_pos_y;
  logic [WAIT_W-1:0] wait_left;

  logic [WORD_W-1:0]   div_reg, div_q_next;
  logic [2*WORD_W-1:0] div_prod;

  logic [WORD_W-1:0] mul_a, mul_b, prod, prod_fx;
  mul_sel_t          mul_dst;
  logic [WORD_W-1:0] pos_x_fx, pos_y_fx;

  function automatic logic [WORD_W-1:0] asr_fx(input logic [WORD_W-1:0] v);
    logic signed [WORD_W-1:0] s;
    begin
      s = $signed(v);
      return WORD_W'(s >>> FRACTION_BITS);
    end
  endfunction

  function automatic logic [WORD_W-1:0] half_fx(input logic [15:0] h);
    logic [WORD_W-1:0] w;
    begin
      w = WORD_W'($signed(h));
      return w << FRACTION_BITS;
    end
  endfunction

  // Multiplying by three in fixed point is a shift-add, scaled and shifted back.
  function automatic logic [WORD_W-1:0] triple_fx(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] s;
    begin
      s = v + {v[WORD_W-2:0], 1'b0};
      return asr_fx(s << FRACTION_BITS);
    end
  endfunction

  assign cfg_ready = 1'b1;

  assign sts.is_start    = (item_cmd == CMD_START);
  assign sts.running     = running;
  assign sts.in_range    = ($signed(curve_param) <= DONE_LIMIT);
  assign sts.wait_nz     = (wait_left != '0);
  assign sts.result_free = !result_valid || !result_stall;

  assign prod_fx  = asr_fx(prod);
  assign pos_x_fx = asr_fx(cur_pos_x);
  assign pos_y_fx = asr_fx(cur_pos_y);

  // Division by five through a reciprocal multiply, exact for every 32-bit value.
  assign div_prod   = {{WORD_W{1'b0}}, div_reg} * {{WORD_W{1'b0}}, RECIP5};
  assign div_q_next = WORD_W'(div_prod >> RECIP_SHIFT);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.mul_sel)
      MUL_PARAM: begin
        mul_a = step_size;
        mul_b = div_reg << FRACTION_BITS;
      end
      MUL_T2:    begin mul_a = curve_param; mul_b = curve_param; end
      MUL_T3:    begin mul_a = t2;          mul_b = curve_param; end
      MUL_LINX:  begin mul_a = lin_x;       mul_b = curve_param; end
      MUL_LINY:  begin mul_a = lin_y;       mul_b = curve_param; end
      MUL_QUADX: begin mul_a = quad_x;      mul_b = t2;          end
      MUL_QUADY: begin mul_a = quad_y;      mul_b = t2;          end
      MUL_CUBEX: begin mul_a = cube_x;      mul_b = t3;          end
      MUL_CUBEY: begin mul_a = cube_y;      mul_b = t3;          end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_point    <= '0;
      first_control  <= '0;
      second_control <= '0;
      end_point      <= '0;
      step_size      <= '0;
      end_wait       <= '0;
      running        <= 1'b0;
      result_valid   <= 1'b0;
      mul_dst        <= MUL_NONE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_START_POINT:    start_point    <= cfg_data;
          REG_FIRST_CONTROL:  first_control  <= cfg_data;
          REG_SECOND_CONTROL: second_control <= cfg_data;
          REG_END_POINT:      end_point      <= cfg_data;
          REG_STEP_SIZE:      step_size      <= cfg_data;
          REG_END_WAIT:       end_wait       <= cfg_data[WAIT_W-1:0];
          default: ;
        endcase
      end
      mul_dst <= ctl.mul_sel;
      if (ctl.coef_op == COEF_DIFF) begin
        running <= 1'b1;
      end
      if (ctl.emit != EMIT_NONE) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod        <= '0;
      item_cmd    <= CMD_START;
      item_tick   <= '0;
      div_reg     <= '0;
      begin_tick  <= '0;
      curve_param <= '0;
      t2          <= '0;
      t3          <= '0;
      lin_x       <= '0;
      lin_y       <= '0;
      quad_x      <= '0;
      quad_y      <= '0;
      cube_x      <= '0;
      cube_y      <= '0;
      cur_pos_x   <= '0;
      cur_pos_y   <= '0;
      wait_left   <= '0;
      active      <= 1'b0;
      pos_x       <= '0;
      pos_y       <= '0;
    end else begin
      prod <= mul_a * mul_b;

      if (ctl.load) begin
        item_cmd  <= cmd;
        item_tick <= tick;
        div_reg   <= tick - begin_tick;
      end else if (ctl.div_step) begin
        div_reg <= div_q_next;
      end

      unique case (ctl.coef_op)
        COEF_DIFF: begin
          lin_x       <= half_fx(first_control[15:0]) - half_fx(start_point[15:0]);
          lin_y       <= half_fx(first_control[31:16]) - half_fx(start_point[31:16]);
          quad_x      <= half_fx(second_control[15:0]) - half_fx(first_control[15:0]);
          quad_y      <= half_fx(second_control[31:16]) - half_fx(first_control[31:16]);
          cube_x      <= half_fx(end_point[15:0]) - half_fx(start_point[15:0]);
          cube_y      <= half_fx(end_point[31:16]) - half_fx(start_point[31:16]);
          cur_pos_x   <= half_fx(start_point[15:0]);
          cur_pos_y   <= half_fx(start_point[31:16]);
          begin_tick  <= item_tick;
          curve_param <= '0;
          wait_left   <= end_wait;
        end
        COEF_TRIPLE: begin
          lin_x  <= triple_fx(lin_x);
          lin_y  <= triple_fx(lin_y);
          quad_x <= triple_fx(quad_x);
          quad_y <= triple_fx(quad_y);
        end
        COEF_SUBLIN: begin
          quad_x <= quad_x - lin_x;
          quad_y <= quad_y - lin_y;
          cube_x <= cube_x - lin_x;
          cube_y <= cube_y - lin_y;
        end
        COEF_SUBQUAD: begin
          cube_x <= cube_x - quad_x;
          cube_y <= cube_y - quad_y;
        end
        COEF_NONE: ;
        default: ;
      endcase

      if (ctl.pos_init) begin
        cur_pos_x <= half_fx(start_point[15:0]);
        cur_pos_y <= half_fx(start_point[31:16]);
      end

      case (mul_dst) inside
        MUL_PARAM:                      curve_param <= prod_fx;
        MUL_T2:                         t2          <= prod_fx;
        MUL_T3:                         t3          <= prod_fx;
        MUL_LINX, MUL_QUADX, MUL_CUBEX: cur_pos_x   <= cur_pos_x + prod_fx;
        MUL_LINY, MUL_QUADY, MUL_CUBEY: cur_pos_y   <= cur_pos_y + prod_fx;
        default: ;
      endcase

      if (ctl.wait_dec) begin
        wait_left <= wait_left - WAIT_W'(1);
      end

      if (ctl.emit == EMIT_POS) begin
        active <= 1'b1;
        pos_x  <= pos_x_fx[POS_W-1:0];
        pos_y  <= pos_y_fx[POS_W-1:0];
      end else if (ctl.emit == EMIT_OFF) begin
        active <= 1'b0;
        pos_x  <= '0;
        pos_y  <= '0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> (ctl.emit == EMIT_NONE))
    else $error("Result register loaded while a stalled result was waiting.");

  a_wait_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctl.wait_dec |-> (wait_left != '0))
    else $error("End wait decremented below zero.");

  a_div_exact: assert property (@(posedge clk) disable iff (rst)
    ctl.div_step |->
      ((div_reg - WORD_W'(div_q_next * WORD_W'(TICK_DIV))) < WORD_W'(TICK_DIV)))
    else $error("Division by five gave a wrong quotient.");

endmodule
`default_nettype wire

@@ tb/sv/tb_cubic_bezier_segment_stepper_unit.sv @@
// Self-checking testbench for the cubic Bezier segment stepper unit.
module tb_cubic_bezier_segment_stepper_unit;
  import bzs_pkg::*;

  localparam int FB = FRAC_BITS_DEF;

  typedef struct packed {
    logic             act;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } seg_pos_t;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  logic                 cmd;
  logic [WORD_W-1:0]    tick;
  logic                 result_valid;
  logic                 result_stall;
  logic                 active;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  cubic_bezier_segment_stepper_unit u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .cmd(cmd),
    .tick(tick),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .active(active),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Register mirror and segment state of the predictor.
  logic [31:0] m_start = '0, m_ctl1 = '0, m_ctl2 = '0, m_end = '0, m_step = '0;
  logic [15:0] m_wait_len = '0;
  logic [31:0] seg_begin = '0, seg_param = '0;
  logic [31:0] seg_lin[2] = '{0, 0}, seg_quad[2] = '{0, 0};
  logic [31:0] seg_cube[2] = '{0, 0}, seg_pos[2] = '{0, 0};
  logic [15:0] seg_wait = '0;
  logic        seg_running = 1'b0;

  seg_pos_t pending_pos_q[$];
  int n_errors = 0;
  int n_checked = 0;
  int n_sent = 0;
  int n_segments = 0;
  int n_writes = 0;
  int gap_max = 16;
  int stall_max = 16;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] fx_asr(input logic [31:0] v);
    return $signed(v) >>> FB;
  endfunction

  function automatic logic [31:0] fx_mul(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] p;
    p = a * b;
    return fx_asr(p);
  endfunction

  function automatic logic [31:0] fx_half(input logic [31:0] pk, input int hi);
    logic [15:0] h;
    h = hi ? pk[31:16] : pk[15:0];
    return {{16{h[15]}}, h} << FB;
  endfunction

  function automatic void push_result(input logic act, input logic [31:0] px,
                                      input logic [31:0] py);
    logic [31:0] fx, fy;
    seg_pos_t r;
    fx = fx_asr(px);
    fy = fx_asr(py);
    r.act = act;
    r.x = fx[POS_W-1:0];
    r.y = fy[POS_W-1:0];
    pending_pos_q = {pending_pos_q, r};
  endfunction

  function automatic void predict_segment_output(input logic c, input logic [31:0] t);
    logic [31:0] s, a, b, e, three, diff, t2, t3;
    three = 32'd3 << FB;
    if (c == CMD_START) begin
      seg_begin = t;
      seg_param = '0;
      seg_wait = m_wait_len;
      for (int ax = 0; ax < 2; ax++) begin
        s = fx_half(m_start, ax);
        a = fx_half(m_ctl1, ax);
        b = fx_half(m_ctl2, ax);
        e = fx_half(m_end, ax);
        seg_lin[ax] = fx_mul(a - s, three);
        seg_quad[ax] = fx_mul(b - a, three) - seg_lin[ax];
        seg_cube[ax] = e - s - seg_lin[ax] - seg_quad[ax];
        seg_pos[ax] = s;
      end
      seg_running = 1'b1;
      push_result(1'b1, seg_pos[0], seg_pos[1]);
    end else if (!seg_running) begin
      push_result(1'b0, '0, '0);
    end else if ($signed(seg_param) <= DONE_LIMIT) begin
      diff = t - seg_begin;
      diff = diff / TICK_DIV;
      seg_param = fx_mul(m_step, diff << FB);
      t2 = fx_mul(seg_param, seg_param);
      t3 = fx_mul(t2, seg_param);
      for (int ax = 0; ax < 2; ax++) begin
        seg_pos[ax] = fx_half(m_start, ax) + fx_mul(seg_lin[ax], seg_param)
                    + fx_mul(seg_quad[ax], t2) + fx_mul(seg_cube[ax], t3);
      end
      push_result(1'b1, seg_pos[0], seg_pos[1]);
    end else if (seg_wait > 0) begin
      seg_wait = seg_wait - 16'd1;
      push_result(1'b1, seg_pos[0], seg_pos[1]);
    end else begin
      push_result(1'b0, '0, '0);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    $display("mismatch at result %0d, %s: got %0h, expected %0h", n_checked, what, got, want);
  endtask

  task automatic check_result();
    seg_pos_t e;
    if (pending_pos_q.size() == 0) begin
      report_mismatch("result transfer with nothing expected", 32'({active, pos_x}), '0);
    end else begin
      e = pending_pos_q.pop_front();
      if (active !== e.act) report_mismatch("active", 32'(active), 32'(e.act));
      if (pos_x !== e.x) report_mismatch("pos_x", 32'($unsigned(pos_x)), 32'(e.x));
      if (pos_y !== e.y) report_mismatch("pos_y", 32'($unsigned(pos_y)), 32'(e.y));
    end
    n_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hold_left = 0;
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        check_result();
        hold_left = $urandom_range(0, stall_max);
      end else if (result_valid && hold_left > 0) begin
        hold_left--;
      end
      result_stall <= (hold_left > 0);
    end
  end

  task automatic send_item(input logic c, input logic [31:0] t);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd <= c;
    tick <= t;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_segment_output(c, t);
    n_sent++;
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_pos_q.size() != 0);
  endtask

  // The caller lowers cfg_valid after the last write of a group.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_START_POINT:    m_start = d;
      REG_FIRST_CONTROL:  m_ctl1 = d;
      REG_SECOND_CONTROL: m_ctl2 = d;
      REG_END_POINT:      m_end = d;
      REG_STEP_SIZE:      m_step = d;
      REG_END_WAIT:       m_wait_len = d[15:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic load_segment_regs(input logic [31:0] sp, input logic [31:0] c1,
                                   input logic [31:0] c2, input logic [31:0] ep,
                                   input logic [31:0] st, input logic [15:0] ew);
    write_reg(REG_START_POINT, sp);
    write_reg(REG_FIRST_CONTROL, c1);
    write_reg(REG_SECOND_CONTROL, c2);
    write_reg(REG_END_POINT, ep);
    write_reg(REG_STEP_SIZE, st);
    write_reg(REG_END_WAIT, {16'h0000, ew});
    cfg_valid <= 1'b0;
    n_segments++;
  endtask

  task automatic test_before_start();
    send_item(CMD_ADVANCE, 32'h0000_0000);
    send_item(CMD_ADVANCE, 32'hFFFF_FFFF);
  endtask

  // Full curve with tick wrap, a live start point change, the end wait and the inactive tail.
  task automatic test_curve_extremes();
    wait_idle();
    load_segment_regs(32'h7FFF_8000, 32'h8000_7FFF, 32'hFFFF_0001, 32'h0001_FFFF,
                      32'd64, 16'd2);
    send_item(CMD_START, 32'hFFFF_FFFD);
    send_item(CMD_ADVANCE, 32'hFFFF_FFFD);
    send_item(CMD_ADVANCE, 32'h0000_0001);
    send_item(CMD_ADVANCE, 32'h0000_0002);
    send_item(CMD_ADVANCE, 32'd40);
    wait_idle();
    write_reg(REG_START_POINT, 32'h8000_7FFF);
    cfg_valid <= 1'b0;
    send_item(CMD_ADVANCE, 32'd60);
    send_item(CMD_ADVANCE, 32'd80);
    send_item(CMD_ADVANCE, 32'd81);
    send_item(CMD_ADVANCE, 32'd82);
    send_item(CMD_ADVANCE, 32'd83);
  endtask

  task automatic test_step_extremes();
    wait_idle();
    load_segment_regs($urandom, $urandom, $urandom, $urandom, 32'h8000_0000, 16'd0);
    send_item(CMD_START, 32'd100);
    send_item(CMD_ADVANCE, 32'd105);
    send_item(CMD_ADVANCE, 32'hFFFF_FFFF);
    wait_idle();
    load_segment_regs($urandom, $urandom, $urandom, $urandom, 32'h7FFF_FFFF, 16'hFFFF);
    send_item(CMD_START, 32'd0);
    send_item(CMD_ADVANCE, 32'd5);
    send_item(CMD_ADVANCE, 32'd10000);
    send_item(CMD_ADVANCE, 32'hFFFF_FFFF);
    wait_idle();
    load_segment_regs($urandom, $urandom, $urandom, $urandom, 32'd0, 16'd0);
    send_item(CMD_START, 32'd7);
    send_item(CMD_ADVANCE, 32'd5007);
  endtask

  task automatic run_segment(input int max_items);
    logic [31:0] t, st;
    logic [15:0] ew;
    int n, tail, r;
    wait_idle();
    if ($urandom_range(0, 3) == 0) begin
      gap_max = 0;
      stall_max = 0;
    end else begin
      gap_max = 16;
      stall_max = 16;
    end
    r = $urandom_range(0, 9);
    if (r == 0) st = $urandom;
    else if (r == 1) st = -$urandom_range(20, 120);
    else st = $urandom_range(20, 120);
    r = $urandom_range(0, 19);
    if (r == 0) ew = 16'hFFFF;
    else if (r < 6) ew = 16'd0;
    else ew = 16'($urandom_range(1, 6));
    load_segment_regs($urandom, $urandom, $urandom, $urandom, st, ew);
    t = $urandom;
    send_item(CMD_START, t);
    n = 0;
    tail = 0;
    while (n < max_items && tail < 2) begin
      r = $urandom_range(0, 39);
      if (r == 0) begin
        send_item(1'($urandom_range(0, 1)), $urandom);
      end else if (r == 1 && n > 3) begin
        send_item(CMD_START, t);
      end else if (r == 2) begin
        wait_idle();
        write_reg(REG_START_POINT, $urandom);
        cfg_valid <= 1'b0;
      end else begin
        t = t + $urandom_range(0, 25);
        send_item(CMD_ADVANCE, t);
      end
      if (seg_running && $signed(seg_param) > DONE_LIMIT && seg_wait == 0) tail++;
      n++;
    end
  endtask

  task automatic test_random_segments();
    while (n_sent < 540) run_segment(45);
  endtask

  task automatic test_random_noise();
    wait_idle();
    gap_max = 16;
    stall_max = 16;
    load_segment_regs($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 300),
                      16'($urandom_range(0, 3)));
    for (int i = 0; i < 110; i++) begin
      if (i == 55) begin
        gap_max = 0;
        stall_max = 0;
      end
      send_item(($urandom_range(0, 4) == 0) ? CMD_START : CMD_ADVANCE, $urandom);
    end
  endtask

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    cmd <= CMD_START;
    tick <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_START_POINT;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_before_start();
    test_curve_extremes();
    test_step_extremes();
    test_random_segments();
    test_random_noise();
    wait_idle();
    repeat (40) @(posedge clk);
    $display("Sent %0d items over %0d segment setups with %0d register writes.",
             n_sent, n_segments, n_writes);
    $display("Checked %0d results, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && pending_pos_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
